// ----- rtl/two_group_permutation_enumerator_core_macros.svh -----
// Assertion macros for the two-group permutation enumerator.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef TWO_GROUP_PERMUTATION_ENUMERATOR_CORE_MACROS_SVH
`define TWO_GROUP_PERMUTATION_ENUMERATOR_CORE_MACROS_SVH

// same-cycle implication
`define TGPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TGPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tgpe_pkg.sv -----
// Shared constants, register codes and handshake structs for the enumerator.
// No dependencies.
package tgpe_pkg;

    localparam int MAX_ITEMS  = 16;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int NIB_W      = 4;
    localparam int WORD_W     = MAX_ITEMS * NIB_W;
    localparam int CNT_W      = IDX_W + 1;
    localparam int SEQ_W      = 45;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MODE  = 2'd2;

    // effective (clamped) configuration
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] k;
        logic             full;
    } tgpe_cfg_t;

    typedef struct packed {
        logic start;
        logic restart;
    } tgpe_cmd_t;

    typedef struct packed {
        logic fin;
        logic ok;
        logic last;
    } tgpe_sts_t;

endpackage

// ----- rtl/tgpe_engine.sv -----
// Order register file and the sequencer that restarts, checks, advances
// and looks ahead on it. Uses tgpe_pkg.
module tgpe_engine
    import tgpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tgpe_cfg_t         cfg,
    input  tgpe_cmd_t         cmd,
    output tgpe_sts_t         sts,
    output logic [WORD_W-1:0] order_word
);

    localparam logic [3:0] E_IDLE  = 4'd0;
    localparam logic [3:0] E_INIT  = 4'd1;
    localparam logic [3:0] E_PERM  = 4'd2;
    localparam logic [3:0] E_FSRCH = 4'd3;
    localparam logic [3:0] E_FSUCC = 4'd4;
    localparam logic [3:0] E_FSWP1 = 4'd5;
    localparam logic [3:0] E_FSWP2 = 4'd6;
    localparam logic [3:0] E_REVA  = 4'd7;
    localparam logic [3:0] E_REVB  = 4'd8;
    localparam logic [3:0] E_REVC  = 4'd9;
    localparam logic [3:0] E_GSRCH = 4'd10;
    localparam logic [3:0] E_GSET  = 4'd11;
    localparam logic [3:0] E_GFILL = 4'd12;
    localparam logic [3:0] E_FIN   = 4'd13;

    localparam logic [MAX_ITEMS-1:0] ONE_HOT = {{(MAX_ITEMS-1){1'b0}}, 1'b1};

    logic [NIB_W-1:0] ord_reg [MAX_ITEMS];

    logic [3:0]           st_reg, st_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [NIB_W-1:0]     pv_reg, pv_next;
    logic [NIB_W-1:0]     prev_reg, prev_next;
    logic [NIB_W-1:0]     t_reg, t_next;
    logic [NIB_W-1:0]     cbest_reg, cbest_next;
    logic [MAX_ITEMS-1:0] mask_reg, mask_next;
    logic [MAX_ITEMS-1:0] used_reg, used_next;
    logic [MAX_ITEMS-1:0] ubest_reg, ubest_next;
    logic                 look_reg, look_next;
    logic                 asc_reg, asc_next;
    logic                 found_reg, found_next;
    logic                 ok_reg, ok_next;
    logic                 last_reg, last_next;

    // single read port, single write port
    logic [IDX_W-1:0] rd_addr;
    logic [NIB_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [NIB_W-1:0] wr_data;
    logic             init_all;

    logic             srch_go;
    logic             fin_go;
    logic             fin_ok;
    logic             fin_last;

    logic [IDX_W-1:0] nm1;
    logic [IDX_W-1:0] km1;
    logic [NIB_W-1:0] base;
    logic [NIB_W:0]   cand;
    logic [NIB_W+1:0] lhs;
    logic [NIB_W+1:0] rhs;
    logic             feas;
    logic             found_all;

    assign nm1     = cfg.n[IDX_W-1:0] - 1'b1;
    assign km1     = cfg.k - 1'b1;
    assign rd_data = ord_reg[rd_addr];

    // filtered search: candidate first value and room check c + k <= n + i
    assign base      = (idx_reg != '0 && prev_reg > rd_data) ? prev_reg : rd_data;
    assign cand      = {1'b0, base} + 1'b1;
    assign lhs       = {1'b0, cand} + {2'b00, cfg.k};
    assign rhs       = {1'b0, cfg.n} + {2'b00, idx_reg};
    assign feas      = asc_reg && (lhs <= rhs);
    assign found_all = found_reg | feas;

    always_comb
    begin
        st_next    = st_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        best_next  = best_reg;
        pv_next    = pv_reg;
        prev_next  = prev_reg;
        t_next     = t_reg;
        cbest_next = cbest_reg;
        mask_next  = mask_reg;
        used_next  = used_reg;
        ubest_next = ubest_reg;
        look_next  = look_reg;
        asc_next   = asc_reg;
        found_next = found_reg;
        ok_next    = ok_reg;
        last_next  = last_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        init_all   = 1'b0;
        srch_go    = 1'b0;
        fin_go     = 1'b0;
        fin_ok     = 1'b0;
        fin_last   = 1'b0;

        case (st_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.restart)
                    begin
                        st_next = E_INIT;
                    end
                    else
                    begin
                        st_next   = E_PERM;
                        idx_next  = '0;
                        mask_next = '0;
                    end
                end
            end

            E_INIT:
            begin
                init_all  = 1'b1;
                srch_go   = 1'b1;
                look_next = 1'b1;
            end

            // check the first n entries form a permutation of 0..n-1
            E_PERM:
            begin
                rd_addr = idx_reg;
                if (({1'b0, rd_data} >= cfg.n) || mask_reg[rd_data])
                begin
                    fin_go = 1'b1;
                end
                else
                begin
                    mask_next = mask_reg | (ONE_HOT << rd_data);
                    if (idx_reg == nm1)
                    begin
                        srch_go   = 1'b1;
                        look_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            // pivot scan, from the tail down
            E_FSRCH:
            begin
                rd_addr = idx_reg;
                if (idx_reg == nm1)
                begin
                    prev_next = rd_data;
                    idx_next  = idx_reg - 1'b1;
                end
                else if (rd_data < prev_reg)
                begin
                    if (look_reg)
                    begin
                        fin_go = 1'b1;
                        fin_ok = 1'b1;
                    end
                    else
                    begin
                        i_next   = idx_reg;
                        pv_next  = rd_data;
                        idx_next = nm1;
                        st_next  = E_FSUCC;
                    end
                end
                else if (idx_reg == '0)
                begin
                    fin_go   = 1'b1;
                    fin_ok   = look_reg;
                    fin_last = look_reg;
                end
                else
                begin
                    prev_next = rd_data;
                    idx_next  = idx_reg - 1'b1;
                end
            end

            E_FSUCC:
            begin
                rd_addr = idx_reg;
                if (rd_data > pv_reg)
                begin
                    t_next  = rd_data;
                    hi_next = idx_reg;
                    st_next = E_FSWP1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end

            E_FSWP1:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = pv_reg;
                st_next = E_FSWP2;
            end

            E_FSWP2:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = t_reg;
                lo_next = i_reg + 1'b1;
                hi_next = nm1;
                st_next = E_REVA;
            end

            // reverse the tail: one swap per pass through E_REVA, E_REVB and E_REVC
            E_REVA:
            begin
                if (lo_reg >= hi_reg)
                begin
                    srch_go   = 1'b1;
                    look_next = 1'b1;
                end
                else
                begin
                    rd_addr = lo_reg;
                    t_next  = rd_data;
                    st_next = E_REVB;
                end
            end

            E_REVB:
            begin
                rd_addr = hi_reg;
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rd_data;
                st_next = E_REVC;
            end

            E_REVC:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = t_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_reg - 1'b1;
                st_next = E_REVA;
            end

            // first group scan, keeps the highest position that can be raised
            E_GSRCH:
            begin
                rd_addr = idx_reg;
                if (idx_reg == km1)
                begin
                    if (look_reg)
                    begin
                        fin_go   = 1'b1;
                        fin_ok   = 1'b1;
                        fin_last = !found_all;
                    end
                    else if (!found_all)
                    begin
                        fin_go = 1'b1;
                    end
                    else
                    begin
                        idx_next  = feas ? idx_reg : best_reg;
                        t_next    = feas ? cand[NIB_W-1:0] : cbest_reg;
                        used_next = feas ? mask_reg : ubest_reg;
                        st_next   = E_GSET;
                    end
                end
                else
                begin
                    if (feas)
                    begin
                        found_next = 1'b1;
                        best_next  = idx_reg;
                        cbest_next = cand[NIB_W-1:0];
                        ubest_next = mask_reg;
                    end
                    mask_next = mask_reg | (ONE_HOT << rd_data);
                    asc_next  = asc_reg && (idx_reg == '0 || rd_data > prev_reg);
                    prev_next = rd_data;
                    idx_next  = idx_reg + 1'b1;
                end
            end

            E_GSET:
            begin
                wr_en     = 1'b1;
                wr_addr   = idx_reg;
                wr_data   = t_reg;
                used_next = used_reg | (ONE_HOT << t_reg);
                if (idx_reg == km1)
                begin
                    idx_next = '0;
                    lo_next  = cfg.k;
                    st_next  = E_GFILL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    t_next   = t_reg + 1'b1;
                end
            end

            // second group: unused values in ascending order
            E_GFILL:
            begin
                if (!used_reg[idx_reg])
                begin
                    wr_en   = 1'b1;
                    wr_addr = lo_reg;
                    wr_data = idx_reg;
                    lo_next = lo_reg + 1'b1;
                end
                if (idx_reg == nm1)
                begin
                    srch_go   = 1'b1;
                    look_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            E_FIN:
            begin
                st_next = E_IDLE;
            end

            default:
            begin
                st_next = E_IDLE;
            end
        endcase

        if (srch_go)
        begin
            if (cfg.full)
            begin
                st_next  = E_FSRCH;
                idx_next = nm1;
            end
            else
            begin
                st_next    = E_GSRCH;
                idx_next   = '0;
                asc_next   = 1'b1;
                mask_next  = '0;
                found_next = 1'b0;
            end
        end

        if (fin_go)
        begin
            st_next   = E_FIN;
            ok_next   = fin_ok;
            last_next = fin_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= E_IDLE;
            look_reg  <= 1'b0;
            asc_reg   <= 1'b0;
            found_reg <= 1'b0;
            ok_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            look_reg  <= look_next;
            asc_reg   <= asc_next;
            found_reg <= found_next;
            ok_reg    <= ok_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        i_reg     <= i_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        best_reg  <= best_next;
        pv_reg    <= pv_next;
        prev_reg  <= prev_next;
        t_reg     <= t_next;
        cbest_reg <= cbest_next;
        mask_reg  <= mask_next;
        used_reg  <= used_next;
        ubest_reg <= ubest_next;
    end

    // order store: identity after reset and on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_ITEMS; e++)
            begin
                ord_reg[e] <= NIB_W'(e);
            end
        end
        else if (init_all)
        begin
            for (int e = 0; e < MAX_ITEMS; e++)
            begin
                ord_reg[e] <= NIB_W'(e);
            end
        end
        else if (wr_en)
        begin
            ord_reg[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        for (int e = 0; e < MAX_ITEMS; e++)
        begin
            order_word[e*NIB_W +: NIB_W] = ord_reg[e];
        end
    end

    assign sts.fin  = (st_reg == E_FIN);
    assign sts.ok   = ok_reg;
    assign sts.last = last_reg;

endmodule

// ----- rtl/two_group_permutation_enumerator_core.sv -----
// Two-group permutation enumerator: each beat on the input asks for the identity
// (restart = 1) or the next permutation of 0..n-1 in lexicographic order; in
// filtered mode only permutations whose first k places and remaining places are
// each ascending are returned. One result beat answers every input beat. The
// block works on one request at a time and holds in_stall high meanwhile; a
// request keeps it high through the permutation check, the pivot scan and the
// successor scan, the swaps of the tail reversal (or the group scan, the group
// rewrite and the fill in filtered mode) and the look-ahead that sets is_last,
// all paced by the single read port of the 16-entry order register file in
// tgpe_engine, plus any wait for a stalled result register. A request after
// exhaustion skips the engine. Results wait in an output register, so the
// result side may stall without losing a beat. Depends on tgpe_pkg,
// tgpe_engine and the assertion macro header.
`include "two_group_permutation_enumerator_core_macros.svh"

module two_group_permutation_enumerator_core
    import tgpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WORD_W-1:0]     perm_word,
    output logic [SEQ_W-1:0]      sequence_number,
    output logic                  exhausted,
    output logic                  is_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            state_reg;
    logic [CNT_W-1:0]      item_count_reg;
    logic [IDX_W-1:0]      group_size_reg;
    logic                  full_mode_reg;
    logic                  done_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic                  rst_flag_reg;
    logic                  res_exh_reg;
    logic                  res_last_reg;
    logic                  out_valid_reg;
    logic [WORD_W-1:0]     perm_word_reg;
    logic [SEQ_W-1:0]      seq_out_reg;
    logic                  exh_out_reg;
    logic                  last_out_reg;

    tgpe_cfg_t             cfg;
    tgpe_cmd_t             cmd;
    tgpe_sts_t             sts;
    logic [WORD_W-1:0]     eng_word;
    logic [WORD_W-1:0]     masked_word;
    logic                  in_acc;
    logic                  out_load;

    // clamp n to 2..16 and k to 1..n-1
    always_comb
    begin
        if (item_count_reg < CNT_W'(2))
        begin
            cfg.n = CNT_W'(2);
        end
        else if (item_count_reg > CNT_W'(MAX_ITEMS))
        begin
            cfg.n = CNT_W'(MAX_ITEMS);
        end
        else
        begin
            cfg.n = item_count_reg;
        end

        if (group_size_reg == '0)
        begin
            cfg.k = IDX_W'(1);
        end
        else if ({1'b0, group_size_reg} >= cfg.n)
        begin
            cfg.k = cfg.n[IDX_W-1:0] - 1'b1;
        end
        else
        begin
            cfg.k = group_size_reg;
        end

        cfg.full = full_mode_reg;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // a request after exhaustion needs no engine pass
    assign cmd.start   = in_acc && (restart || !done_reg);
    assign cmd.restart = restart;

    tgpe_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .order_word (eng_word)
    );

    // places at and above n read as zero
    always_comb
    begin
        for (int e = 0; e < MAX_ITEMS; e++)
        begin
            masked_word[e*NIB_W +: NIB_W] =
                (CNT_W'(e) < cfg.n) ? eng_word[e*NIB_W +: NIB_W] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= CNT_W'(2);
            group_size_reg <= IDX_W'(1);
            full_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ITEM_COUNT: item_count_reg <= cfg_data[CNT_W-1:0];
                CFG_GROUP_SIZE: group_size_reg <= cfg_data[IDX_W-1:0];
                CFG_FULL_MODE:  full_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // request sequencing, done flag and beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            seq_reg      <= '0;
            rst_flag_reg <= 1'b0;
            res_exh_reg  <= 1'b0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        rst_flag_reg <= restart;
                        if (restart)
                        begin
                            seq_reg   <= '0;
                            done_reg  <= 1'b0;
                            state_reg <= S_RUN;
                        end
                        else if (done_reg)
                        begin
                            res_exh_reg  <= 1'b1;
                            res_last_reg <= 1'b0;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_RUN;
                        end
                    end
                end

                S_RUN:
                begin
                    if (sts.fin)
                    begin
                        if (rst_flag_reg || sts.ok)
                        begin
                            res_exh_reg  <= 1'b0;
                            res_last_reg <= sts.last;
                            if (!rst_flag_reg)
                            begin
                                seq_reg <= seq_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            done_reg     <= 1'b1;
                            res_exh_reg  <= 1'b1;
                            res_last_reg <= 1'b0;
                        end
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            perm_word_reg <= masked_word;
            seq_out_reg   <= seq_reg;
            exh_out_reg   <= res_exh_reg;
            last_out_reg  <= res_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign perm_word       = perm_word_reg;
    assign sequence_number = seq_out_reg;
    assign exhausted       = exh_out_reg;
    assign is_last         = last_out_reg;

    `TGPE_ASSERT_IMP(a_exh_not_last, out_valid_reg && exh_out_reg, !last_out_reg, "exhausted beat marked last")
    `TGPE_ASSERT_IMP(a_fin_in_run, sts.fin, state_reg == S_RUN, "engine finished outside a request")
    `TGPE_ASSERT_NXT(a_count_frozen, done_reg && !(in_acc && restart), $stable(seq_reg), "count moved after exhaustion")

endmodule
